/* rtl/core/sts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg: shared constants and divider steps
// Command codes, register indexes, reset values and the restoring-division
// steps used by the shader pipeline.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int SCREEN_HEIGHT_DEF = 512;
	localparam int TEX_DIM_DEF       = 256;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_NORMAL = 2'd1;
	localparam logic [1:0] CMD_GLOW   = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	localparam logic [7:0] ALPHA_NORMAL = 8'h80;
	localparam logic [7:0] ALPHA_GLOW   = 8'h30;

	localparam logic [2:0] REG_FRAME_COUNT = 3'd0;
	localparam logic [2:0] REG_NORMAL_W    = 3'd1;
	localparam logic [2:0] REG_NORMAL_H    = 3'd2;
	localparam logic [2:0] REG_GLOW_W      = 3'd3;
	localparam logic [2:0] REG_GLOW_H      = 3'd4;
	localparam logic [2:0] REG_FOG_RGB     = 3'd5;
	localparam logic [2:0] REG_LIGHT_DIST  = 3'd6;
	localparam logic [2:0] REG_MAX_DIST    = 3'd7;

	localparam logic [7:0]  RST_FRAME_COUNT = 8'd1;
	localparam logic [8:0]  RST_DIM         = 9'd256;
	localparam logic [30:0] RST_DIST        = 31'd1;

	// one quotient bit: returns {remainder, shifted dividend/quotient}
	function automatic logic [16:0] fw_step(logic [7:0] rem, logic [8:0] dq, logic [7:0] d);
		logic [8:0] t;
		logic [7:0] r;
		logic       b;
		t = {rem, dq[8]};
		if (t >= {1'b0, d}) begin
			r = 8'(t - {1'b0, d});
			b = 1'b1;
		end else begin
			r = t[7:0];
			b = 1'b0;
		end
		return {r, dq[7:0], b};
	endfunction

	function automatic logic [33:0] uv_step(logic [11:0] rem, logic [21:0] dq, logic [11:0] d);
		logic [12:0] t;
		logic [11:0] r;
		logic        b;
		t = {rem, dq[21]};
		if (t >= {1'b0, d}) begin
			r = 12'(t - {1'b0, d});
			b = 1'b1;
		end else begin
			r = t[11:0];
			b = 1'b0;
		end
		return {r, dq[20:0], b};
	endfunction

	function automatic logic [69:0] fog_step(logic [30:0] rem, logic [38:0] dq, logic [30:0] d);
		logic [31:0] t;
		logic [30:0] r;
		logic        b;
		t = {rem, dq[38]};
		if (t >= {1'b0, d}) begin
			r = 31'(t - {1'b0, d});
			b = 1'b1;
		end else begin
			r = t[30:0];
			b = 1'b0;
		end
		return {r, dq[37:0], b};
	endfunction

endpackage
`default_nettype wire

/* rtl/core/sprite_texel_shader.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_texel_shader: per-pixel sprite sheet shader
// Loads texels into a normal or glow bank and shades pixels by mapping them
// into the animated sheet, fetching the texel and computing fog alpha.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        input      in_valid / in_stall       command .. distance
// out       output     out_valid / out_stall     out_x .. fog_colour
// cfg       input      psel penable pwrite       paddr pwdata -> prdata
//
// One request per cycle unless stalled, through 41 stages; the depth is set by
// the 39-step fog divider ahead of the texture memory port.
// Loads travel the pipe and write at the memory stage, in order with shades.
// Each stage advances when the next is free; a held result stalls only the
// stages behind it. Reset clears valid and config registers, not data or texels.
// ----------------------------------------------------------------------------
module sprite_texel_shader #(
	parameter int SCREEN_HEIGHT = sts_pkg::SCREEN_HEIGHT_DEF,
	parameter int TEX_DIM       = sts_pkg::TEX_DIM_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         command,
	input  wire logic               tex_bank,
	input  wire logic [15:0]        tex_index,
	input  wire logic [31:0]        texel,
	input  wire logic [9:0]         pixel_x,
	input  wire logic [8:0]         pixel_y,
	input  wire logic signed [12:0] sprite_left,
	input  wire logic [11:0]        sprite_size,
	input  wire logic [7:0]         frame,
	input  wire logic [30:0]        distance,

	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [9:0]              out_x,
	output logic [8:0]              out_y,
	output logic                    draw,
	output logic [31:0]             sprite_colour,
	output logic [31:0]             fog_colour,

	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int AW         = 2 * $clog2(TEX_DIM);
	localparam int ST_FW0     = 2;
	localparam int FW_N       = 9;
	localparam int ST_MUL     = ST_FW0 + FW_N;
	localparam int ST_UV0     = ST_MUL + 1;
	localparam int UV_N       = 22;
	localparam int ST_SGN     = ST_UV0 + UV_N;
	localparam int ST_WV      = ST_SGN + 1;
	localparam int ST_FOG0    = 2;
	localparam int FOG_N      = 39;
	localparam int ST_FOG_END = ST_FOG0 + FOG_N - 1;
	localparam int ST_ADR     = (ST_WV + 1 > ST_FOG_END) ? ST_WV + 1 : ST_FOG_END;
	localparam int ST_OUT     = ST_ADR + 1;

	typedef struct packed {
		logic [1:0]    cmd;
		logic          bank;
		logic [AW-1:0] idx;
		logic [31:0]   texel;
		logic [9:0]    x;
		logic [8:0]    y;
		logic [7:0]    frame;
		logic [8:0]    w;
		logic [8:0]    h;
		logic [11:0]   size;
		logic          sxneg;
		logic          syneg;
		logic [12:0]   sxmag;
		logic [12:0]   symag;
		logic [7:0]    fc;
		logic [8:0]    fwdq;
		logic [7:0]    fwrem;
		logic [16:0]   ffw;
		logic [21:0]   udq;
		logic [11:0]   urem;
		logic [21:0]   vdq;
		logic [11:0]   vrem;
		logic [30:0]   fdiv;
		logic [38:0]   fogdq;
		logic [30:0]   fogrem;
		logic [AW-1:0] u;
		logic [AW-1:0] v;
		logic [AW-1:0] wv;
	} stage_t;

	// configuration
	logic [7:0]  frame_count_q;
	logic [8:0]  normal_width_q;
	logic [8:0]  normal_height_q;
	logic [8:0]  glow_width_q;
	logic [8:0]  glow_height_q;
	logic [23:0] fog_rgb_q;
	logic [30:0] light_distance_q;
	logic [30:0] max_distance_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q    <= sts_pkg::RST_FRAME_COUNT;
			normal_width_q   <= sts_pkg::RST_DIM;
			normal_height_q  <= sts_pkg::RST_DIM;
			glow_width_q     <= sts_pkg::RST_DIM;
			glow_height_q    <= sts_pkg::RST_DIM;
			fog_rgb_q        <= '0;
			light_distance_q <= sts_pkg::RST_DIST;
			max_distance_q   <= sts_pkg::RST_DIST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				sts_pkg::REG_FRAME_COUNT: frame_count_q    <= pwdata[7:0];
				sts_pkg::REG_NORMAL_W:    normal_width_q   <= pwdata[8:0];
				sts_pkg::REG_NORMAL_H:    normal_height_q  <= pwdata[8:0];
				sts_pkg::REG_GLOW_W:      glow_width_q     <= pwdata[8:0];
				sts_pkg::REG_GLOW_H:      glow_height_q    <= pwdata[8:0];
				sts_pkg::REG_FOG_RGB:     fog_rgb_q        <= pwdata[23:0];
				sts_pkg::REG_LIGHT_DIST:  light_distance_q <= pwdata[30:0];
				sts_pkg::REG_MAX_DIST:    max_distance_q   <= pwdata[30:0];
				default:                  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			sts_pkg::REG_FRAME_COUNT: prdata = {24'd0, frame_count_q};
			sts_pkg::REG_NORMAL_W:    prdata = {23'd0, normal_width_q};
			sts_pkg::REG_NORMAL_H:    prdata = {23'd0, normal_height_q};
			sts_pkg::REG_GLOW_W:      prdata = {23'd0, glow_width_q};
			sts_pkg::REG_GLOW_H:      prdata = {23'd0, glow_height_q};
			sts_pkg::REG_FOG_RGB:     prdata = {8'd0, fog_rgb_q};
			sts_pkg::REG_LIGHT_DIST:  prdata = {1'b0, light_distance_q};
			sts_pkg::REG_MAX_DIST:    prdata = {1'b0, max_distance_q};
			default:                  prdata = '0;
		endcase
	end

	// pipeline
	stage_t          stage_q [1:ST_OUT];
	stage_t          nxt     [1:ST_OUT];
	stage_t          in_stage;
	logic [ST_OUT:1] vld_q;
	logic [ST_OUT:1] en;
	logic            in_take;
	logic [31:0]     ram_rdata;
	logic            ram_en;

	assign in_stall = !en[1];
	assign in_take  = in_valid && en[1];

	always_comb begin
		en[ST_OUT] = !(out_valid && out_stall);
		for (int k = ST_OUT - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k + 1];
		end
	end

	// stage 1: select bank settings and form signed offsets
	logic              glow;
	logic [30:0]       div_sel;
	logic signed [13:0] sx;
	logic signed [13:0] ht;
	logic signed [13:0] starty;
	logic signed [13:0] sy;
	logic [11:0]       size_fix;

	always_comb begin
		glow     = (command == sts_pkg::CMD_GLOW);
		size_fix = (sprite_size == 12'd0) ? 12'd1 : sprite_size;
		div_sel  = glow ? max_distance_q : light_distance_q;
		sx       = $signed({4'd0, pixel_x}) - $signed({sprite_left[12], sprite_left});
		ht       = $signed(14'(SCREEN_HEIGHT)) - $signed({2'd0, size_fix});
		starty   = (ht + $signed({13'd0, ht[13]})) >>> 1;
		sy       = $signed({5'd0, pixel_y}) - starty;

		in_stage        = '0;
		in_stage.cmd    = command;
		in_stage.bank   = (command == sts_pkg::CMD_LOAD) ? tex_bank : glow;
		in_stage.idx    = AW'(tex_index);
		in_stage.texel  = texel;
		in_stage.x      = pixel_x;
		in_stage.y      = pixel_y;
		in_stage.frame  = frame;
		in_stage.w      = glow ? glow_width_q : normal_width_q;
		in_stage.h      = glow ? glow_height_q : normal_height_q;
		in_stage.size   = size_fix;
		in_stage.sxneg  = sx[13];
		in_stage.syneg  = sy[13];
		in_stage.sxmag  = sx[13] ? 13'(-sx) : sx[12:0];
		in_stage.symag  = sy[13] ? 13'(-sy) : sy[12:0];
		in_stage.fc     = (frame_count_q == 8'd0) ? 8'd1 : frame_count_q;
		in_stage.fwdq   = glow ? glow_width_q : normal_width_q;
		in_stage.fdiv   = (div_sel == 31'd0) ? 31'd1 : div_sel;
		in_stage.fogdq  = ({8'd0, distance} << 8) - {8'd0, distance};
	end

	always_comb begin
		nxt[1] = in_stage;
		for (int k = 2; k <= ST_OUT; k++) begin
			nxt[k] = stage_q[k - 1];
			if (k >= ST_FW0 && k < ST_FW0 + FW_N) begin
				{nxt[k].fwrem, nxt[k].fwdq} =
					sts_pkg::fw_step(nxt[k].fwrem, nxt[k].fwdq, nxt[k].fc);
			end
			if (k >= ST_FOG0 && k <= ST_FOG_END) begin
				{nxt[k].fogrem, nxt[k].fogdq} =
					sts_pkg::fog_step(nxt[k].fogrem, nxt[k].fogdq, nxt[k].fdiv);
			end
			if (k == ST_MUL) begin
				nxt[k].udq  = 22'(nxt[k].sxmag) * 22'(nxt[k].fwdq);
				nxt[k].vdq  = 22'(nxt[k].symag) * 22'(nxt[k].h);
				nxt[k].ffw  = 17'(nxt[k].frame) * 17'(nxt[k].fwdq);
				nxt[k].urem = '0;
				nxt[k].vrem = '0;
			end
			if (k >= ST_UV0 && k < ST_UV0 + UV_N) begin
				{nxt[k].urem, nxt[k].udq} =
					sts_pkg::uv_step(nxt[k].urem, nxt[k].udq, nxt[k].size);
				{nxt[k].vrem, nxt[k].vdq} =
					sts_pkg::uv_step(nxt[k].vrem, nxt[k].vdq, nxt[k].size);
			end
			if (k == ST_SGN) begin
				nxt[k].u = (nxt[k].sxneg ? -AW'(nxt[k].udq) : AW'(nxt[k].udq))
					+ AW'(nxt[k].ffw);
				nxt[k].v = nxt[k].syneg ? -AW'(nxt[k].vdq) : AW'(nxt[k].vdq);
			end
			if (k == ST_WV) begin
				nxt[k].wv = AW'(nxt[k].w) * nxt[k].v;
			end
			if (k == ST_ADR && nxt[k].cmd != sts_pkg::CMD_LOAD) begin
				nxt[k].idx = nxt[k].wv + nxt[k].u;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_take && (command != sts_pkg::CMD_NONE);
			end
			for (int k = 2; k <= ST_OUT; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= ST_OUT; k++) begin
			if (en[k]) begin
				stage_q[k] <= nxt[k];
			end
		end
	end

	// texture memory: bank bit above the wrapped texel index
	assign ram_en = vld_q[ST_ADR] && en[ST_OUT];

	sts_ram #(
		.WIDTH(32),
		.DEPTH(2 * TEX_DIM * TEX_DIM)
	) u_tex_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (stage_q[ST_ADR].cmd == sts_pkg::CMD_LOAD),
		.addr  ({stage_q[ST_ADR].bank, stage_q[ST_ADR].idx}),
		.wdata (stage_q[ST_ADR].texel),
		.rdata (ram_rdata)
	);

	assign out_valid     = vld_q[ST_OUT] && (stage_q[ST_OUT].cmd != sts_pkg::CMD_LOAD);
	assign out_x         = stage_q[ST_OUT].x;
	assign out_y         = stage_q[ST_OUT].y;
	assign sprite_colour = ram_rdata;
	assign draw          = stage_q[ST_OUT].bank ? (ram_rdata[7:0] > sts_pkg::ALPHA_GLOW)
	                                            : (ram_rdata[7:0] > sts_pkg::ALPHA_NORMAL);
	assign fog_colour    = {fog_rgb_q, stage_q[ST_OUT].fogdq[7:0]};

endmodule
`default_nettype wire

/* rtl/core/sts_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_ram: single-port synchronous RAM
// One read or one write per cycle; read data registered and held between reads.
// ----------------------------------------------------------------------------
module sts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire
